// ----- rtl/rcnsf_pkg.sv -----
// Shared types and constants for the radius crossmatch new-source filter.
package rcnsf_pkg;

   typedef logic [1:0] op_type;

   localparam op_type OP_LOAD  = 2'd0;
   localparam op_type OP_QUERY = 2'd1;
   localparam op_type OP_CLEAR = 2'd2;

   localparam int POS_W    = 24;
   localparam int FLUX_W   = 32;
   localparam int RADIUS_W = 32;
   localparam int DIFF_W   = POS_W + 1;
   localparam int SQ_W     = 2 * POS_W + 1;
   localparam int DIST_W   = SQ_W + 1;
   localparam int REF_W    = 2 * POS_W;

   localparam logic [RADIUS_W-1:0] RADIUS_SQ_RESET = 32'd65536;

   typedef struct packed {
      op_type                   operation;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [FLUX_W-1:0] flux;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  new_x;
      logic signed [POS_W-1:0]  new_y;
      logic signed [FLUX_W-1:0] new_flux;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic ref_write;
      logic ref_clear;
      logic query_start;
      logic scan_issue;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic scan_last;
      logic pipe_empty;
      logic matched;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/rcnsf_ram.sv -----
// Generic simple dual-port RAM with registered read.
module rcnsf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rcnsf_ctrl.sv -----
// Controller state machine: request intake, scan sequencing, result hand-off.
module rcnsf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  rcnsf_pkg::op_type       req_operation,
   output logic                    req_ready,
   input  rcnsf_pkg::status_type   status,
   output rcnsf_pkg::cmd_type      cmd
);

   import rcnsf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_operation == OP_QUERY) begin
               state_in = status.count_zero ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.matched || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      cmd             = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.ref_write   = req_valid && (req_operation == OP_LOAD);
            cmd.ref_clear   = req_valid && (req_operation == OP_CLEAR);
            cmd.query_start = req_valid && (req_operation == OP_QUERY);
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            cmd.out_load = !status.matched && status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/rcnsf_dp.sv -----
// Datapath: reference store, distance pipeline, match flag and result register.
module rcnsf_dp #(
   parameter int REF_DEPTH = 4096,
   localparam int ADDR_W  = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1,
   localparam int COUNT_W = $clog2(REF_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rcnsf_pkg::req_type      req_data,
   input  logic                    csr_wr_en,
   input  logic [31:0]             csr_wr_data,
   input  rcnsf_pkg::cmd_type      cmd,
   output rcnsf_pkg::status_type   status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rcnsf_pkg::rsp_type      rsp_data
);

   import rcnsf_pkg::*;

   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]         scan_idx_ff, scan_idx_in;
   req_type                   query_ff;
   logic [2:0]                pipe_vld_ff, pipe_vld_in;
   logic signed [DIFF_W-1:0]  diff_x_ff, diff_y_ff, diff_x_in, diff_y_in;
   logic [SQ_W-1:0]           sq_x_ff, sq_y_ff;
   logic signed [2*DIFF_W-1:0] prod_x, prod_y;
   logic [DIST_W-1:0]         dist_sq;
   logic                      hit;
   logic                      matched_ff, matched_in;
   logic [RADIUS_W-1:0]       radius_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff;
   logic                      full;
   logic                      wr_en;
   logic [REF_W-1:0]          rd_data;
   logic [POS_W-1:0]          ref_x, ref_y;

   assign full  = (count_ff == COUNT_W'(REF_DEPTH));
   assign wr_en = cmd.ref_write && !full;

   rcnsf_ram #(
      .WIDTH (REF_W),
      .DEPTH (REF_DEPTH)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_data.pos_x, req_data.pos_y}),
      .rd_en   (cmd.scan_issue),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   assign ref_x = rd_data[REF_W-1:POS_W];
   assign ref_y = rd_data[POS_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (cmd.ref_clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.query_start) begin
         scan_idx_in = '0;
      end else if (cmd.scan_issue) begin
         scan_idx_in = scan_idx_ff + ADDR_W'(1);
      end
   end

   assign pipe_vld_in = {pipe_vld_ff[1:0], cmd.scan_issue};

   // exact differences, squares and sum; no overflow at these widths
   assign diff_x_in = {ref_x[POS_W-1], ref_x} - {query_ff.pos_x[POS_W-1], query_ff.pos_x};
   assign diff_y_in = {ref_y[POS_W-1], ref_y} - {query_ff.pos_y[POS_W-1], query_ff.pos_y};
   assign prod_x    = diff_x_ff * diff_x_ff;
   assign prod_y    = diff_y_ff * diff_y_ff;
   assign dist_sq   = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   assign hit       = (dist_sq <= {{(DIST_W-RADIUS_W){1'b0}}, radius_ff});

   always_comb begin
      matched_in = matched_ff;
      if (cmd.query_start) begin
         matched_in = 1'b0;
      end else if (pipe_vld_ff[2] && hit) begin
         matched_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pipe_vld_ff  <= '0;
         matched_ff   <= 1'b0;
         radius_ff    <= RADIUS_SQ_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pipe_vld_ff  <= pipe_vld_in;
         matched_ff   <= matched_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      diff_x_ff   <= diff_x_in;
      diff_y_ff   <= diff_y_in;
      sq_x_ff     <= prod_x[SQ_W-1:0];
      sq_y_ff     <= prod_y[SQ_W-1:0];
      if (cmd.query_start) begin
         query_ff <= req_data;
      end
      if (cmd.out_load) begin
         rsp_data_ff.new_x    <= query_ff.pos_x;
         rsp_data_ff.new_y    <= query_ff.pos_y;
         rsp_data_ff.new_flux <= query_ff.flux;
      end
   end

   assign status.count_zero = (count_ff == '0);
   assign status.scan_last  = ((COUNT_W'(scan_idx_ff) + COUNT_W'(1)) == count_ff);
   assign status.pipe_empty = (pipe_vld_ff == '0);
   assign status.matched    = matched_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/radius_crossmatch_new_source_filter.sv -----
// Loads and clears are taken in ST_IDLE and leave it there. A query scans the
// store one RAM entry per cycle through the distance pipeline's RAM read,
// difference and square registers, then drains them; an empty store skips the
// scan. No request is taken until the query is done. The result register frees
// the input side while one result waits; a further new source waits in ST_FINISH.
// Sync reset empties the store count and output, radius back to 1.0; RAM untouched.
module radius_crossmatch_new_source_filter #(
   parameter int REF_DEPTH = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rcnsf_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rcnsf_pkg::rsp_type   rsp_data,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data
);

   import rcnsf_pkg::*;

   cmd_type    cmd;
   status_type status;

   rcnsf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   rcnsf_dp #(
      .REF_DEPTH (REF_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_issue |-> !status.count_zero)
      else $error("scan issued with empty reference store");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.operation == OP_CLEAR) |=> status.count_zero)
      else $error("clear request did not empty the store");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("result appeared without an output load");

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      !status.pipe_empty |-> !req_ready)
      else $error("request accepted while distance pipeline busy");

endmodule

// ----- test/radius_crossmatch_new_source_filter_tb.sv -----
// Self-checking testbench for the radius crossmatch new-source filter.
module radius_crossmatch_new_source_filter_tb;
   import rcnsf_pkg::*;

   localparam int REF_DEPTH   = 4096;
   localparam int HOLD_SPAN   = 400;
   localparam int QUIET_LIMIT = 8 * (REF_DEPTH + HOLD_SPAN);
   localparam op_type OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [RADIUS_W-1:0] csr_wr_data = '0;

   // mirror of the reference catalogue and the radius register
   logic signed [POS_W-1:0] catalog_x [REF_DEPTH];
   logic signed [POS_W-1:0] catalog_y [REF_DEPTH];
   int catalog_count = 0;
   logic [RADIUS_W-1:0] radius_sq = RADIUS_SQ_RESET;

   req_type requests_pending [$];
   rsp_type new_sources_due [$];
   rsp_type want;
   int planned_count = 0;
   int offered = 0;
   int scan_span = 0;
   int quiet_cycles = 0;
   int failures = 0;
   int hold_left = 0;
   bit req_taken = 1'b0;
   bit drained = 1'b0;
   bit steady = 1'b0;
   bit hold_request = 1'b0;

   radius_crossmatch_new_source_filter #(
      .REF_DEPTH(REF_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // true when some stored reference lies within the radius of the query
   function automatic bit lies_near_catalog(logic signed [POS_W-1:0] qx,
                                            logic signed [POS_W-1:0] qy);
      longint dx;
      longint dy;
      for (int i = 0; i < catalog_count; i++) begin
         dx = longint'(catalog_x[i]) - longint'(qx);
         dy = longint'(catalog_y[i]) - longint'(qy);
         if (dx * dx + dy * dy <= longint'(radius_sq)) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic offer(op_type op, int x, int y, int f);
      req_type r;
      r.operation = op;
      r.pos_x = POS_W'(x);
      r.pos_y = POS_W'(y);
      r.flux = f;
      requests_pending.push_back(r);
      offered++;
      if (op == OP_LOAD && planned_count < REF_DEPTH) planned_count++;
      else if (op == OP_CLEAR) planned_count = 0;
   endtask

   task automatic write_radius(logic [RADIUS_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait for every request taken and every new source seen, then let a
   // trailing matched query finish its scan
   task automatic settle();
      @(posedge clock);
      do @(negedge clock); while (!drained);
      repeat (scan_span + 16) @(negedge clock);
      scan_span = 0;
   endtask

   task automatic run_random(logic [RADIUS_W-1:0] radius, int span, int count);
      int seeds_x [$];
      int seeds_y [$];
      int stop;
      int pick;
      write_radius(radius);
      @(posedge clock);
      stop = offered + count;
      while (offered < stop) begin
         if ($urandom_range(99) < 12) begin
            offer(op_type'($urandom_range(3)), $urandom, $urandom, $urandom);
         end else begin
            if (planned_count > 48 || $urandom_range(2) == 0)
               offer(OP_CLEAR, $urandom, $urandom, $urandom);
            seeds_x.delete();
            seeds_y.delete();
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(1) == 1) begin
                  seeds_x.push_back($urandom);
                  seeds_y.push_back($urandom);
               end else begin
                  seeds_x.push_back(int'($urandom_range(8191)) - 4096);
                  seeds_y.push_back(int'($urandom_range(8191)) - 4096);
               end
               offer(OP_LOAD, seeds_x[$], seeds_y[$], $urandom);
            end
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(9) < 7) begin
                  pick = $urandom_range(seeds_x.size() - 1);
                  offer(OP_QUERY,
                        seeds_x[pick] + int'($urandom_range(2 * span)) - span,
                        seeds_y[pick] + int'($urandom_range(2 * span)) - span,
                        $urandom);
               end else begin
                  offer(OP_QUERY, $urandom, $urandom, $urandom);
               end
            end
         end
      end
      settle();
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (requests_pending.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
            req_valid <= 1'b1;
            req_data <= requests_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_SPAN;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 12);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         catalog_count = 0;
         radius_sq = RADIUS_SQ_RESET;
         req_taken = 1'b0;
         quiet_cycles = 0;
      end else begin
         if (csr_wr_en) radius_sq = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (new_sources_due.size() == 0) begin
               failures++;
               $display("%0t: new source x=%0d y=%0d flux=%0d with none expected",
                        $time, rsp_data.new_x, rsp_data.new_y, rsp_data.new_flux);
            end else begin
               want = new_sources_due.pop_front();
               if (rsp_data.new_x !== want.new_x) begin
                  failures++;
                  $display("%0t: new_x expected %0d got %0d",
                           $time, want.new_x, rsp_data.new_x);
               end
               if (rsp_data.new_y !== want.new_y) begin
                  failures++;
                  $display("%0t: new_y expected %0d got %0d",
                           $time, want.new_y, rsp_data.new_y);
               end
               if (rsp_data.new_flux !== want.new_flux) begin
                  failures++;
                  $display("%0t: new_flux expected %0d got %0d",
                           $time, want.new_flux, rsp_data.new_flux);
               end
            end
         end
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            case (req_data.operation)
               OP_LOAD: begin
                  if (catalog_count < REF_DEPTH) begin
                     catalog_x[catalog_count] = req_data.pos_x;
                     catalog_y[catalog_count] = req_data.pos_y;
                     catalog_count++;
                  end
               end
               OP_CLEAR: catalog_count = 0;
               OP_QUERY: begin
                  if (catalog_count > scan_span) scan_span = catalog_count;
                  if (!lies_near_catalog(req_data.pos_x, req_data.pos_y)) begin
                     want.new_x = req_data.pos_x;
                     want.new_y = req_data.pos_y;
                     want.new_flux = req_data.flux;
                     new_sources_due.push_back(want);
                  end
               end
               default: ;
            endcase
         end
         if (req_taken || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
      drained = requests_pending.size() == 0 && (!req_valid || req_taken)
                && new_sources_due.size() == 0;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default radius of one pixel, i.e. 256 position units
      offer(OP_QUERY, 8388607, -8388608, 32'h8000_0000);
      offer(OP_QUERY, -8388608, 8388607, 32'h7FFF_FFFF);
      offer(OP_LOAD, 0, 0, 0);
      offer(OP_QUERY, 256, 0, 1);       // exactly on the radius: match
      offer(OP_QUERY, 257, 0, 2);
      offer(OP_QUERY, 181, 181, 3);
      offer(OP_QUERY, 0, -256, 4);
      offer(OP_LOAD, 8388607, 8388607, 0);
      offer(OP_LOAD, -8388608, -8388608, 0);
      offer(OP_QUERY, -8388608, 8388607, -1);
      offer(OP_QUERY, 8388607, 8388607 - 256, 5);
      offer(OP_QUERY, -8388608 + 100, -8388608 + 100, 6);
      offer(OP_UNUSED, 5000, 5000, 7);
      offer(OP_CLEAR, 0, 0, 0);
      offer(OP_QUERY, 0, 0, 8);         // empty store after clear
      offer(OP_LOAD, -1, -1, 0);
      offer(OP_QUERY, -1, -1, 9);
      offer(OP_QUERY, -1, 255, 10);
      offer(OP_QUERY, -1, 256, 11);
      settle();

      run_random(32'd0, 2, 18);
      run_random(32'hFFFF_FFFF, 50000, 18);
      @(posedge clock);
      steady = 1'b1;
      run_random(32'd589824, 1000, 18);
      @(posedge clock);
      steady = 1'b0;

      // results back up behind a stalled receiver while requests keep coming
      @(posedge clock);
      hold_request = 1'b1;
      offer(OP_CLEAR, 0, 0, 0);
      repeat (20) offer(OP_QUERY, $urandom, $urandom, $urandom);
      settle();

      run_random($urandom, 40000, 18);

      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
